>>> src/lattice_growth_grid_engine_defines.svh
// Assertion macros for the lattice growth grid engine checker.
// Needs a clk and an arst_n signal in the scope where a macro is used.
`ifndef LATTICE_GROWTH_GRID_ENGINE_DEFINES_SVH
`define LATTICE_GROWTH_GRID_ENGINE_DEFINES_SVH

// Property holds in the same cycle as its trigger.
`define LGGE_ASSERT_SAME(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

// Property holds in the cycle after its trigger.
`define LGGE_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

>>> src/lgge_pkg.sv
// Shared types, constants and helper functions of the lattice growth grid engine.
// No dependencies.
package lgge_pkg;

	localparam int GRID_WIDTH = 64;
	localparam int GRID_ROWS  = 64;
	localparam int COL_W      = 6;
	localparam int ROW_W      = 6;
	localparam int ADDR_W     = COL_W + ROW_W;
	localparam int CELLS      = GRID_WIDTH * GRID_ROWS;
	localparam int RCNT_W     = 7;
	localparam int MUT_W      = 13;
	localparam int CNT_W      = 12;
	localparam logic [MUT_W-1:0] MUT_MAX = 13'd8191;
	localparam logic [RCNT_W-1:0] ROW_FULL = 7'(GRID_WIDTH);

	typedef enum logic [2:0] {
		KIND_CLEAR  = 3'd0,
		KIND_PLACE  = 3'd1,
		KIND_EMPTY  = 3'd2,
		KIND_READ   = 3'd3,
		KIND_PICK   = 3'd4,
		KIND_RETIRE = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTIED  = 3'd1,
		ST_FRONT    = 3'd2,
		ST_NO_OCC   = 3'd3,
		ST_NO_EMPTY = 3'd4
	} status_t;

	localparam logic [1:0] CELL_EMPTY  = 2'd0;
	localparam logic [1:0] CELL_WILD   = 2'd1;
	localparam logic [1:0] CELL_MUTANT = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [5:0]  x;
		logic [15:0] y;
		logic [1:0]  cell_type;
		logic [15:0] rand_first;
		logic [15:0] rand_second;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  cell_value;
		logic [5:0]  pick_x;
		logic [15:0] pick_y;
		logic [12:0] mutant_count;
		logic [15:0] low_row;
		logic [15:0] high_row;
		logic        row_retired;
		logic [2:0]  status;
	} out_item_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CLEAR,
		S_ACC_RD,
		S_ACC_EX,
		S_NBR_RD,
		S_PICK1,
		S_PICK1_W,
		S_PICK2,
		S_PICK2_S,
		S_PICK2_W,
		S_RET_RD,
		S_RET_CHK,
		S_RET_SW,
		S_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic             load;
		logic             acc_rd;
		logic             acc_ex;
		logic             nbr_rd;
		logic             pick_chk;
		logic             mod_start;
		logic             mod_sel;
		logic             take_k1;
		logic             near_ld;
		logic             take_pick;
		logic             ret_rd;
		logic             row_sweep;
		logic             ret_commit;
		logic             clr_sweep;
		logic             clr_commit;
		logic             load_out;
		logic [CNT_W-1:0] cnt;
	} dp_cmd_t;

	typedef struct packed {
		logic row_absent;
		logic pick_fail;
		logic mod_done;
		logic ret_ok;
	} dp_stat_t;

	// Neighbor order: dx outer, dy inner, center skipped. Codes 0,1,2 mean -1,0,+1.
	function automatic logic [1:0] nbr_dx(input logic [2:0] idx);
		logic [1:0] r;
		case (idx)
			3'd0, 3'd1, 3'd2: r = 2'd0;
			3'd3, 3'd4:       r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] nbr_dy(input logic [2:0] idx);
		logic [1:0] r;
		case (idx)
			3'd0, 3'd3, 3'd5: r = 2'd0;
			3'd1, 3'd6:       r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] abs_diff2(input logic [1:0] a, input logic [1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// Index of the k-th set bit of mask, counting from bit 0.
	function automatic logic [2:0] sel_kth(input logic [7:0] mask, input logic [2:0] k);
		logic [3:0] seen;
		logic [2:0] r;
		seen = '0;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (mask[i]) begin
				if (seen == {1'b0, k})
					r = 3'(i);
				seen = seen + 4'd1;
			end
		end
		return r;
	endfunction

endpackage

>>> src/lgge_modu.sv
// Bit-serial remainder unit: dividend modulo a small divisor, one bit per cycle.
// Depends on nothing outside itself.
module lgge_modu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [3:0]  divisor,
	output logic        done,
	output logic [3:0]  rem
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  step_q;
	logic [3:0]  rem_q;
	logic [15:0] dvd_q;
	logic [3:0]  dsr_q;
	logic [4:0]  trial;
	logic [4:0]  nxt;

	assign trial = {rem_q, dvd_q[15]};
	assign nxt   = (trial >= {1'b0, dsr_q}) ? (trial - {1'b0, dsr_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= nxt[3:0];
			dvd_q <= {dvd_q[14:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> src/lgge_ctrl.sv
// Controller state machine of the lattice growth grid engine.
// Depends on lgge_pkg; drives the datapath through dp_cmd_t.
module lgge_ctrl
	import lgge_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic [2:0] in_kind,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t      state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.cnt  = cnt_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_INIT, S_CLEAR: begin
				cmd.clr_sweep = 1'b1;
				cnt_d = cnt_q + 12'd1;
				if (cnt_q == 12'(CELLS - 1)) begin
					cnt_d = '0;
					if (state_q == S_INIT) begin
						state_d = S_IDLE;
					end else begin
						cmd.clr_commit = 1'b1;
						state_d = S_FIN;
					end
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				cnt_d = '0;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_kind)
						KIND_CLEAR:                       state_d = S_CLEAR;
						KIND_PLACE, KIND_EMPTY, KIND_READ: state_d = S_ACC_RD;
						KIND_PICK:                        state_d = S_NBR_RD;
						KIND_RETIRE:                      state_d = S_RET_RD;
						default:                          state_d = S_FIN;
					endcase
				end
			end
			S_ACC_RD: begin
				cmd.acc_rd = 1'b1;
				state_d = stat.row_absent ? S_FIN : S_ACC_EX;
			end
			S_ACC_EX: begin
				cmd.acc_ex = 1'b1;
				state_d = S_FIN;
			end
			S_NBR_RD: begin
				cmd.nbr_rd = 1'b1;
				cnt_d = cnt_q + 12'd1;
				if (cnt_q == 12'd8) begin
					cnt_d = '0;
					state_d = S_PICK1;
				end
			end
			S_PICK1: begin
				cmd.pick_chk = 1'b1;
				if (stat.pick_fail) begin
					state_d = S_FIN;
				end else begin
					cmd.mod_start = 1'b1;
					state_d = S_PICK1_W;
				end
			end
			S_PICK1_W: begin
				if (stat.mod_done) begin
					cmd.take_k1 = 1'b1;
					state_d = S_PICK2;
				end
			end
			S_PICK2: begin
				cmd.near_ld = 1'b1;
				state_d = S_PICK2_S;
			end
			S_PICK2_S: begin
				cmd.mod_start = 1'b1;
				cmd.mod_sel = 1'b1;
				state_d = S_PICK2_W;
			end
			S_PICK2_W: begin
				cmd.mod_sel = 1'b1;
				if (stat.mod_done) begin
					cmd.take_pick = 1'b1;
					state_d = S_FIN;
				end
			end
			S_RET_RD: begin
				cmd.ret_rd = 1'b1;
				cnt_d = cnt_q + 12'd1;
				if (cnt_q == 12'd3) begin
					cnt_d = '0;
					state_d = S_RET_CHK;
				end
			end
			S_RET_CHK: begin
				cnt_d = '0;
				state_d = stat.ret_ok ? S_RET_SW : S_FIN;
			end
			S_RET_SW: begin
				cmd.row_sweep = 1'b1;
				cnt_d = cnt_q + 12'd1;
				if (cnt_q == 12'(GRID_WIDTH - 1)) begin
					cnt_d = '0;
					cmd.ret_commit = 1'b1;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> src/lgge_dp.sv
// Datapath of the lattice growth grid engine: cell store, row counts, marks, pick logic.
// Depends on lgge_pkg and lgge_modu; steered by lgge_ctrl through dp_cmd_t.
module lgge_dp
	import lgge_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat,
	input  in_item_t  in_data,
	input  logic      cfg_we,
	input  logic      cfg_lin,
	output out_item_t out_data
);

	logic [1:0]        cell_mem [CELLS];
	logic [RCNT_W-1:0] rc_mem [GRID_ROWS];

	in_item_t          item_q;
	logic              lin_q;
	logic [MUT_W-1:0]  mut_q;
	logic [15:0]       oldest_q;
	logic [15:0]       top_q;
	logic [1:0]        value_q;
	logic [2:0]        status_q;
	logic              retired_q;
	logic [7:0]        occ_q;
	logic [2:0]        full_q;
	logic [2:0]        k1_q;
	logic [7:0]        near_q;
	logic [5:0]        px_q;
	logic [15:0]       py_q;
	out_item_t         out_q;

	logic [ADDR_W-1:0] cell_raddr, cell_waddr;
	logic [1:0]        cell_rdata, cell_wdata;
	logic              cell_we;
	logic [ROW_W-1:0]  rc_raddr, rc_waddr;
	logic [RCNT_W-1:0] rc_rdata, rc_wdata;
	logic              rc_we;

	logic              row_absent;
	logic [ADDR_W-1:0] item_addr;
	logic [7:0]        pres, occm, empm;
	logic [3:0]        nf, ne, nm;
	logic [2:0]        org, pidx, nidx, cap_idx;
	logic [3:0]        sqd [8];
	logic [3:0]        best;
	logic [7:0]        near_d;
	logic [16:0]       nrow [8];
	logic [5:0]        ncol [8];
	logic [1:0]        new_type;
	logic [MUT_W-1:0]  mut_dec, mut_place;
	logic              mod_done;
	logic [3:0]        mod_rem;
	logic [15:0]       ret_row;

	assign row_absent = !lin_q && (item_q.y[15:ROW_W] != '0);
	assign item_addr  = {item_q.y[ROW_W-1:0], item_q.x};
	assign new_type   = (item_q.cell_type == CELL_MUTANT) ? CELL_MUTANT : CELL_WILD;
	assign nidx       = cmd.cnt[2:0];
	assign cap_idx    = 3'(cmd.cnt - 12'd1);
	assign ret_row    = oldest_q + 16'(cmd.cnt);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			ncol[i] = item_q.x + 6'(nbr_dx(3'(i))) - 6'd1;
			nrow[i] = {1'b0, item_q.y} + 17'(nbr_dy(3'(i))) - 17'd1;
			pres[i] = !(item_q.y == '0 && nbr_dy(3'(i)) == 2'd0) &&
				(lin_q || nrow[i] < 17'(GRID_ROWS));
		end
	end

	assign occm = occ_q & pres;
	assign empm = ~occ_q & pres;
	assign nf   = 4'($countones(occm));
	assign ne   = 4'($countones(empm));
	assign nm   = 4'($countones(near_q));
	assign org  = sel_kth(occm, k1_q);
	assign pidx = sel_kth(near_q, mod_rem[2:0]);

	always_comb begin
		logic [1:0] ax, ay;
		best = 4'd15;
		for (int i = 0; i < 8; i++) begin
			ax = abs_diff2(nbr_dx(3'(i)), nbr_dx(org));
			ay = abs_diff2(nbr_dy(3'(i)), nbr_dy(org));
			sqd[i] = 4'(ax * ax) + 4'(ay * ay);
			if (empm[i] && sqd[i] < best)
				best = sqd[i];
		end
		for (int i = 0; i < 8; i++)
			near_d[i] = empm[i] && (sqd[i] == best);
	end

	lgge_modu u_modu (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (cmd.mod_sel ? item_q.rand_second : item_q.rand_first),
		.divisor  (cmd.mod_sel ? nm : nf),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign mut_dec   = (cell_rdata == CELL_MUTANT && mut_q != '0) ? mut_q - 13'd1 : mut_q;
	assign mut_place = (new_type == CELL_MUTANT && mut_dec < MUT_MAX) ?
		mut_dec + 13'd1 : mut_dec;

	always_comb begin
		cell_raddr = cmd.nbr_rd ? {nrow[nidx][ROW_W-1:0], ncol[nidx]} : item_addr;
		rc_raddr   = cmd.ret_rd ? ret_row[ROW_W-1:0] : item_q.y[ROW_W-1:0];
		cell_we    = 1'b0;
		cell_waddr = item_addr;
		cell_wdata = CELL_EMPTY;
		rc_we      = 1'b0;
		rc_waddr   = item_q.y[ROW_W-1:0];
		rc_wdata   = '0;
		if (cmd.clr_sweep) begin
			cell_we    = 1'b1;
			cell_waddr = cmd.cnt[ADDR_W-1:0];
			rc_we      = (cmd.cnt[CNT_W-1:ROW_W] == '0);
			rc_waddr   = cmd.cnt[ROW_W-1:0];
		end else if (cmd.row_sweep) begin
			cell_we    = 1'b1;
			cell_waddr = {oldest_q[ROW_W-1:0], cmd.cnt[COL_W-1:0]};
			rc_we      = (cmd.cnt == '0);
			rc_waddr   = oldest_q[ROW_W-1:0];
		end else if (cmd.acc_ex) begin
			if (item_q.kind == KIND_PLACE) begin
				cell_we    = 1'b1;
				cell_wdata = new_type;
				rc_we      = (cell_rdata == CELL_EMPTY);
				rc_wdata   = rc_rdata + 7'd1;
			end else if (item_q.kind == KIND_EMPTY && cell_rdata != CELL_EMPTY) begin
				cell_we  = 1'b1;
				rc_we    = 1'b1;
				rc_wdata = (rc_rdata != '0) ? rc_rdata - 7'd1 : rc_rdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cell_we)
			cell_mem[cell_waddr] <= cell_wdata;
		cell_rdata <= cell_mem[cell_raddr];
	end

	always_ff @(posedge clk) begin
		if (rc_we)
			rc_mem[rc_waddr] <= rc_wdata;
		rc_rdata <= rc_mem[rc_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_q    <= 1'b0;
			mut_q    <= '0;
			oldest_q <= '0;
			top_q    <= '0;
		end else begin
			if (cfg_we) begin
				lin_q    <= cfg_lin;
				oldest_q <= '0;
				top_q    <= '0;
			end
			if (cmd.clr_commit) begin
				mut_q <= '0;
				if (lin_q) begin
					oldest_q <= '0;
					top_q    <= '0;
				end
			end
			if (cmd.ret_commit)
				oldest_q <= oldest_q + 16'd1;
			if (cmd.acc_ex) begin
				if (item_q.kind == KIND_PLACE) begin
					mut_q <= mut_place;
					if (lin_q && item_q.y > top_q)
						top_q <= item_q.y;
				end else if (item_q.kind == KIND_EMPTY) begin
					mut_q <= mut_dec;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q    <= in_data;
			value_q   <= CELL_EMPTY;
			status_q  <= ST_OK;
			retired_q <= 1'b0;
			px_q      <= '0;
			py_q      <= '0;
		end
		if (cmd.acc_rd && row_absent)
			status_q <= ST_FRONT;
		if (cmd.acc_ex) begin
			if (item_q.kind == KIND_READ)
				value_q <= cell_rdata;
			else if (item_q.kind == KIND_EMPTY && cell_rdata == CELL_EMPTY)
				status_q <= ST_EMPTIED;
			else if (item_q.kind == KIND_PLACE &&
				{1'b0, item_q.y} >= {1'b0, oldest_q} + 17'(GRID_ROWS - 1))
				status_q <= ST_FRONT;
		end
		if (cmd.nbr_rd && cmd.cnt != '0)
			occ_q[cap_idx] <= (cell_rdata != CELL_EMPTY);
		if (cmd.pick_chk) begin
			if (nf == '0)
				status_q <= ST_NO_OCC;
			else if (ne == '0)
				status_q <= ST_NO_EMPTY;
		end
		if (cmd.take_k1)
			k1_q <= mod_rem[2:0];
		if (cmd.near_ld)
			near_q <= near_d;
		if (cmd.take_pick) begin
			px_q <= ncol[pidx];
			py_q <= nrow[pidx][15:0];
		end
		if (cmd.ret_rd && cmd.cnt != '0)
			full_q[cap_idx[1:0]] <= (rc_rdata == ROW_FULL);
		if (cmd.ret_commit)
			retired_q <= 1'b1;
		if (cmd.load_out) begin
			out_q.cell_value   <= value_q;
			out_q.pick_x       <= px_q;
			out_q.pick_y       <= py_q;
			out_q.mutant_count <= mut_q;
			out_q.low_row      <= oldest_q;
			out_q.high_row     <= top_q;
			out_q.row_retired  <= retired_q;
			out_q.status       <= status_q;
		end
	end

	assign stat.row_absent = row_absent;
	assign stat.pick_fail  = (nf == '0) || (ne == '0);
	assign stat.mod_done   = mod_done;
	assign stat.ret_ok     = &full_q;
	assign out_data        = out_q;

endmodule

>>> src/lattice_growth_grid_engine.sv
// Lattice growth grid engine: 64 x 64 cell lattice with row counts and row marks.
// Input channel in_valid/in_ready/in_data carries one operation per transaction;
// output channel out_valid/out_ready/out_data returns exactly one result per item.
// Config channel cfg_valid/cfg_ready/cfg_data writes the linear mode bit (always ready)
// and zeroes the low and high row marks; write it only while the block is idle.
// Items are handled one at a time. Steps from accept to result valid:
//   place, empty, read: read, then access if the row is in the store; no-op: direct
//   pick: neighbor reads, then, unless the pick fails, two 16-step serial remainders
//   retire: row counts checked, then the row swept unless refused (one cell per cycle)
//   clear: one cell store write per cycle
// After reset the cell store and row counts are swept empty;
// in_ready stays low until then. in_ready is high only when no item is in work.
// The result sits in an output register, so in_ready returns while out_valid
// waits on a stalled receiver; a further finished result waits in the engine.
// Depends on lgge_pkg, lgge_ctrl, lgge_dp, lgge_modu.
module lattice_growth_grid_engine
	import lgge_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	lgge_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_kind   (in_data.kind),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lgge_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (in_data),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_lin  (cfg_data),
		.out_data (out_data)
	);

endmodule

>>> src/lgge_checker.sv
// Port-level checks of the lattice growth grid engine, bound to the top level.
// Depends on lgge_pkg and lattice_growth_grid_engine_defines.svh.
`include "lattice_growth_grid_engine_defines.svh"

module lgge_checker
	import lgge_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	`LGGE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
	`LGGE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second item taken while one is in work")
	`LGGE_ASSERT_SAME(a_retire_ok, out_valid && out_data.row_retired, out_data.status == ST_OK && out_data.cell_value == CELL_EMPTY, "retired row with bad status")
	`LGGE_ASSERT_SAME(a_pick_fail_zero, out_valid && (out_data.status == ST_NO_OCC || out_data.status == ST_NO_EMPTY), out_data.pick_x == '0 && out_data.pick_y == '0, "failed pick returned a cell")

endmodule

bind lattice_growth_grid_engine lgge_checker u_lgge_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

>>> test/tb_top.sv
// Self-checking testbench for lattice_growth_grid_engine: directed and random items with
// random idling on both channels, checked against a behavioral lattice predictor.
// Depends on lgge_pkg and the RTL of the block.
module tb_top;
	import lgge_pkg::*;

	localparam int CYCLE_LIMIT = 30000000;
	localparam int DIST_START  = 100;
	localparam int SETTLE      = 100;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic      cfg_data;

	lattice_growth_grid_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// predicted lattice
	logic [1:0]  cells[CELLS];
	int          row_fill[GRID_ROWS];
	int          mut_total;
	logic [15:0] oldest;
	logic [15:0] top;
	logic        lin;

	in_item_t    pending[$];
	out_item_t   expected_results[$];
	int          errors;
	int          cycle_count;
	logic        in_burst;
	logic        out_burst;

	// values sampled mid-cycle, used at the next rising edge
	logic        in_rdy_s;
	logic        out_vld_s;
	out_item_t   out_dat_s;
	logic        cfg_rdy_s;

	always @(negedge clk) begin
		in_rdy_s  = in_ready;
		out_vld_s = out_valid;
		out_dat_s = out_data;
		cfg_rdy_s = cfg_ready;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic void wipe_lattice();
		for (int i = 0; i < CELLS; i++)
			cells[i] = CELL_EMPTY;
		for (int i = 0; i < GRID_ROWS; i++)
			row_fill[i] = 0;
		mut_total = 0;
	endfunction

	function automatic int ring_row(int yy);
		if (yy < 0)
			return -1;
		if (lin)
			return yy % GRID_ROWS;
		if (yy >= GRID_ROWS)
			return -1;
		return yy;
	endfunction

	function automatic out_item_t lattice_apply(in_item_t it);
		out_item_t r;
		int xx, yy, row, a, cx, cy, cr, nf, ne, nm, best, ax, ay, d, k, ox, oy;
		int i1, i2, i3;
		int fx[8], fy[8], ex[8], ey[8], mx[8], my[8];
		logic [1:0] prev, nt;
		r = '0;
		xx = int'(it.x);
		yy = int'(it.y);
		row = ring_row(yy);
		case (it.kind)
			KIND_CLEAR: begin
				wipe_lattice();
				if (lin) begin
					oldest = '0;
					top = '0;
				end
			end
			KIND_PLACE: begin
				if (row < 0) begin
					r.status = ST_FRONT;
				end else begin
					a = xx + row * GRID_WIDTH;
					prev = cells[a];
					nt = (it.cell_type == CELL_MUTANT) ? CELL_MUTANT : CELL_WILD;
					if (yy >= int'(oldest) + GRID_ROWS - 1)
						r.status = ST_FRONT;
					if (prev == CELL_EMPTY)
						row_fill[row]++;
					if (prev == CELL_MUTANT && mut_total > 0)
						mut_total--;
					if (nt == CELL_MUTANT && mut_total < int'(MUT_MAX))
						mut_total++;
					cells[a] = nt;
					if (lin && it.y > top)
						top = it.y;
				end
			end
			KIND_EMPTY: begin
				if (row < 0) begin
					r.status = ST_FRONT;
				end else begin
					a = xx + row * GRID_WIDTH;
					prev = cells[a];
					if (prev == CELL_EMPTY) begin
						r.status = ST_EMPTIED;
					end else begin
						if (row_fill[row] > 0)
							row_fill[row]--;
						if (prev == CELL_MUTANT && mut_total > 0)
							mut_total--;
						cells[a] = CELL_EMPTY;
					end
				end
			end
			KIND_READ: begin
				if (row < 0)
					r.status = ST_FRONT;
				else
					r.cell_value = cells[xx + row * GRID_WIDTH];
			end
			KIND_PICK: begin
				nf = 0;
				ne = 0;
				nm = 0;
				best = DIST_START;
				for (int dx = -1; dx <= 1; dx++) begin
					for (int dy = -1; dy <= 1; dy++) begin
						if (dx != 0 || dy != 0) begin
							cx = (xx + dx + GRID_WIDTH) % GRID_WIDTH;
							cy = yy + dy;
							cr = ring_row(cy);
							if (cr >= 0) begin
								if (cells[cx + cr * GRID_WIDTH] != CELL_EMPTY) begin
									fx[nf] = cx;
									fy[nf] = cy;
									nf++;
								end else begin
									ex[ne] = cx;
									ey[ne] = cy;
									ne++;
								end
							end
						end
					end
				end
				if (nf == 0) begin
					r.status = ST_NO_OCC;
				end else if (ne == 0) begin
					r.status = ST_NO_EMPTY;
				end else begin
					k = int'(it.rand_first) % nf;
					ox = fx[k];
					oy = fy[k];
					for (int i = 0; i < ne; i++) begin
						ax = (ex[i] > ox) ? ex[i] - ox : ox - ex[i];
						ay = (ey[i] > oy) ? ey[i] - oy : oy - ey[i];
						if (GRID_WIDTH - ax < ax)
							ax = GRID_WIDTH - ax;
						d = ax * ax + ay * ay;
						if (d < best) begin
							nm = 0;
							best = d;
						end
						if (d == best) begin
							mx[nm] = ex[i];
							my[nm] = ey[i];
							nm++;
						end
					end
					k = int'(it.rand_second) % nm;
					r.pick_x = 6'(mx[k]);
					r.pick_y = 16'(my[k]);
				end
			end
			KIND_RETIRE: begin
				i1 = int'(oldest) % GRID_ROWS;
				i2 = (int'(oldest) + 1) % GRID_ROWS;
				i3 = (int'(oldest) + 2) % GRID_ROWS;
				if (row_fill[i1] == GRID_WIDTH && row_fill[i2] == GRID_WIDTH &&
				    row_fill[i3] == GRID_WIDTH) begin
					for (int i = 0; i < GRID_WIDTH; i++)
						cells[i1 * GRID_WIDTH + i] = CELL_EMPTY;
					row_fill[i1] = 0;
					oldest = oldest + 16'd1;
					r.row_retired = 1'b1;
				end
			end
			default: ;
		endcase
		r.mutant_count = 13'(mut_total);
		r.low_row = oldest;
		r.high_row = top;
		return r;
	endfunction

	function automatic int draw_wait(inout logic burst);
		if ($urandom_range(0, 39) == 0)
			burst = ~burst;
		return burst ? 0 : int'($urandom_range(0, 5));
	endfunction

	// input driver: predicts each transaction as it is accepted
	initial begin
		int hold;
		in_valid = 1'b0;
		in_data = '0;
		hold = 0;
		in_burst = 1'b0;
		forever begin
			@(posedge clk);
			if (in_valid && in_rdy_s) begin
				expected_results.insert(expected_results.size(), lattice_apply(in_data));
				void'(pending.pop_front());
				hold = draw_wait(in_burst);
				if (hold == 0 && pending.size() > 0)
					in_data <= pending[0];
				else
					in_valid <= 1'b0;
			end else if (!in_valid && pending.size() > 0 && arst_n) begin
				if (hold == 0) begin
					in_valid <= 1'b1;
					in_data <= pending[0];
				end else begin
					hold--;
				end
			end
		end
	end

	task automatic chk_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	// result receiver and checker
	initial begin
		int stall;
		out_item_t e;
		out_ready = 1'b0;
		stall = 0;
		out_burst = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ready && out_vld_s) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with no expectation pending");
					errors++;
				end else begin
					e = expected_results.pop_front();
					chk_field("cell_value", e.cell_value, out_dat_s.cell_value);
					chk_field("pick_x", e.pick_x, out_dat_s.pick_x);
					chk_field("pick_y", e.pick_y, out_dat_s.pick_y);
					chk_field("mutant_count", e.mutant_count, out_dat_s.mutant_count);
					chk_field("low_row", e.low_row, out_dat_s.low_row);
					chk_field("high_row", e.high_row, out_dat_s.high_row);
					chk_field("row_retired", e.row_retired, out_dat_s.row_retired);
					chk_field("status", e.status, out_dat_s.status);
				end
				stall = draw_wait(out_burst);
				if (stall != 0)
					out_ready <= 1'b0;
			end else if (!out_ready) begin
				if (stall == 0)
					out_ready <= 1'b1;
				else
					stall--;
			end
		end
	end

	task automatic send_item(kind_t kind, int xx, int yy, int ct, int r1, int r2);
		in_item_t it;
		it.kind = kind;
		it.x = 6'(xx);
		it.y = 16'(yy);
		it.cell_type = 2'(ct);
		it.rand_first = 16'(r1);
		it.rand_second = 16'(r2);
		do
			@(negedge clk);
		while (pending.size() >= 4);
		pending.insert(pending.size(), it);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mode(logic val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_rdy_s);
		lin = val;
		oldest = '0;
		top = '0;
		cfg_valid <= 1'b0;
	endtask

	function automatic int rnd_type();
		return ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 3))
		                                   : int'($urandom_range(1, 2));
	endfunction

	task automatic random_items(int n, int y_base, int y_span);
		int bx, by, k, xx, yy, roll;
		kind_t kind;
		bx = 0;
		by = y_base;
		for (int i = 0; i < n; i++) begin
			if (i % 30 == 0) begin
				bx = $urandom_range(0, 63);
				by = y_base + int'($urandom_range(0, y_span));
			end
			roll = $urandom_range(0, 199);
			if (roll == 0)
				kind = KIND_CLEAR;
			else if (roll < 75)
				kind = KIND_PLACE;
			else if (roll < 100)
				kind = KIND_EMPTY;
			else if (roll < 130)
				kind = KIND_READ;
			else if (roll < 185)
				kind = KIND_PICK;
			else if (roll < 194)
				kind = KIND_RETIRE;
			else
				kind = kind_t'($urandom_range(6, 7));
			xx = (bx + int'($urandom_range(0, 4))) % GRID_WIDTH;
			yy = by + int'($urandom_range(0, 4)) - 1;
			if ($urandom_range(0, 15) == 0 || yy < 0 || yy > 65534)
				yy = $urandom_range(0, 65534);
			send_item(kind, xx, yy, rnd_type(), $urandom_range(0, 65535),
			          $urandom_range(0, 65535));
		end
	endtask

	task automatic fill_row(int yy);
		int off;
		off = $urandom_range(0, 63);
		for (int i = 0; i < GRID_WIDTH; i++) begin
			send_item(KIND_PLACE, (i * 37 + off) % GRID_WIDTH, yy, rnd_type(), 0, 0);
			if ($urandom_range(0, 5) == 0)
				send_item($urandom_range(0, 1) ? KIND_READ : KIND_PICK,
				          $urandom_range(0, 63), yy - 1 + int'($urandom_range(0, 2)),
				          1, $urandom_range(0, 65535), $urandom_range(0, 65535));
		end
	endtask

	task automatic test_directed_fixed();
		write_mode(1'b0);
		send_item(KIND_READ, 0, 0, 1, 0, 0);
		send_item(KIND_PLACE, 0, 0, CELL_WILD, 0, 0);
		send_item(KIND_PLACE, 63, 63, CELL_MUTANT, 0, 0);
		send_item(KIND_READ, 63, 63, 1, 0, 0);
		send_item(KIND_PLACE, 0, 0, CELL_MUTANT, 0, 0);
		send_item(KIND_PLACE, 63, 63, 3, 0, 0);
		send_item(KIND_PLACE, 1, 0, 0, 0, 0);
		send_item(KIND_EMPTY, 10, 10, 1, 0, 0);
		send_item(KIND_EMPTY, 1, 0, 1, 0, 0);
		send_item(KIND_PLACE, 5, 64, CELL_WILD, 0, 0);
		send_item(KIND_READ, 5, 65534, 1, 0, 0);
		send_item(KIND_EMPTY, 5, 100, 1, 0, 0);
		send_item(KIND_PICK, 30, 30, 1, 65535, 65535);
		send_item(KIND_PICK, 63, 0, 1, 65535, 0);
		send_item(KIND_PICK, 1, 63, 1, 0, 65535);
		for (int dx = -1; dx <= 1; dx++)
			for (int dy = -1; dy <= 1; dy++)
				if (dx != 0 || dy != 0)
					send_item(KIND_PLACE, 5 + dx, 5 + dy, CELL_WILD, 0, 0);
		send_item(KIND_PICK, 5, 5, 1, 7, 3);
		send_item(KIND_RETIRE, 0, 0, 1, 0, 0);
		send_item(kind_t'(6), 63, 65534, 3, 65535, 65535);
		send_item(kind_t'(7), 0, 0, 0, 0, 0);
		send_item(KIND_CLEAR, 0, 0, 1, 0, 0);
	endtask

	task automatic test_random_fixed();
		random_items(400, 0, 66);
	endtask

	task automatic test_linear_ring();
		write_mode(1'b1);
		send_item(KIND_CLEAR, 0, 0, 1, 0, 0);
		fill_row(0);
		send_item(KIND_RETIRE, 0, 0, 1, 0, 0);
		fill_row(1);
		fill_row(2);
		send_item(KIND_RETIRE, 0, 0, 1, 0, 0);
		for (int r = 3; r < 8; r++) begin
			fill_row(r);
			send_item(KIND_RETIRE, 0, 0, 1, 0, 0);
		end
		send_item(KIND_RETIRE, 0, 0, 1, 0, 0);
		send_item(KIND_PLACE, 7, 5 + GRID_ROWS - 1, CELL_MUTANT, 0, 0);
		send_item(KIND_PLACE, 8, 5 + GRID_ROWS, CELL_WILD, 0, 0);
		send_item(KIND_PLACE, 0, 65534, CELL_MUTANT, 0, 0);
		send_item(KIND_PLACE, 63, 65533, CELL_WILD, 0, 0);
		send_item(KIND_PICK, 63, 65534, 1, 65535, 65535);
		send_item(KIND_PICK, 0, 65534, 1, 1, 2);
		send_item(KIND_READ, 0, 65534, 1, 0, 0);
		send_item(KIND_PICK, 3, 0, 1, 12345, 54321);
		send_item(KIND_CLEAR, 0, 0, 1, 0, 0);
	endtask

	task automatic test_random_linear();
		random_items(300, 0, 70);
	endtask

	task automatic test_mode_back();
		write_mode(1'b0);
		random_items(30, 0, 62);
	endtask

	initial begin
		errors = 0;
		cycle_count = 0;
		wipe_lattice();
		lin = 1'b0;
		oldest = '0;
		top = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_fixed();
		test_random_fixed();
		test_linear_ring();
		test_random_linear();
		test_mode_back();
		wait_idle();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/lgge_pkg.sv
src/lgge_modu.sv
src/lgge_ctrl.sv
src/lgge_dp.sv
src/lattice_growth_grid_engine.sv
src/lgge_checker.sv
test/tb_top.sv
